// ===== rtl/dpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dpfr_pkg
// Shared types and constants for the demand paging frame replacer: item
// payloads, command and register codes, controller/datapath handshake.
// ----------------------------------------------------------------------------
package dpfr_pkg;

  // table sizes; the payload widths below are fixed to these
  localparam int PHYS_FRAMES = 32;
  localparam int VIRT_PAGES  = 256;
  localparam int PAGE_BYTES  = 128;

  localparam int VA_W     = 15;
  localparam int TIME_W   = 32;
  localparam int FRAME_W  = 5;
  localparam int VPAGE_W  = 8;
  localparam int PAGES_W  = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [PAGES_W-1:0] PAGES_RESET = 9'd256;

  typedef enum logic [0:0] {
    CMD_FAULT      = 1'b0,
    CMD_MARK_DIRTY = 1'b1
  } command_t;

  typedef enum logic [0:0] {
    MODE_FIFO = 1'b0,
    MODE_LRU  = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPLACE_MODE = 1'b0,
    REG_PAGES_IN_USE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    command_t            command;
    logic [VA_W-1:0]     virtual_address;
    logic [TIME_W-1:0]   time_stamp;
  } request_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame;
    logic                evicted;
    logic [VPAGE_W-1:0]  victim_page;
    logic                write_back;
    logic                error;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;          // clearing pass, one page entry
    logic accept;         // latch the new item
    logic finish;         // hit / dirty / error: update and report
    logic alloc;          // take the next free frame
    logic fifo_take;      // victim from queue head
    logic scan_start;     // start LRU scan
    logic take_best;      // victim from LRU scan
    logic st_from_fp;     // page state read address from frame->page data
    logic capture_victim; // latch victim page
    logic evict;          // unmap victim
    logic map;            // map faulting page, queue frame, report
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic err;
    logic mark_dirty;
    logic hit;
    logic full;
    logic lru;
    logic scan_done;
  } stat_t;

endpackage

// ===== rtl/dpfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpfr_ctrl
// Sequencer for the frame replacer: clearing pass, lookup, allocation or
// victim selection, eviction and mapping.
// ----------------------------------------------------------------------------
module dpfr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dpfr_pkg::stat_t  stat,
  output dpfr_pkg::ctl_t   ctl
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_LOOK  = 9'b000000100,
    S_CHECK = 9'b000001000,
    S_SCAN  = 9'b000010000,
    S_VREAD = 9'b000100000,
    S_SREAD = 9'b001000000,
    S_EVICT = 9'b010000000,
    S_MAP   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.err || stat.mark_dirty || stat.hit) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end else if (!stat.full) begin
          ctl.alloc  = 1'b1;
          state_next = S_MAP;
        end else if (stat.lru) begin
          ctl.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          ctl.fifo_take = 1'b1;
          state_next    = S_VREAD;
        end
      end
      S_SCAN: begin
        ctl.st_from_fp = 1'b1;
        if (stat.scan_done) begin
          ctl.take_best = 1'b1;
          state_next    = S_VREAD;
        end
      end
      S_VREAD: begin
        state_next = S_SREAD;
      end
      S_SREAD: begin
        ctl.st_from_fp     = 1'b1;
        ctl.capture_victim = 1'b1;
        state_next         = S_EVICT;
      end
      S_EVICT: begin
        ctl.evict  = 1'b1;
        state_next = S_MAP;
      end
      S_MAP: begin
        ctl.map    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/dpfr_dpath.sv =====
// ----------------------------------------------------------------------------
// dpfr_dpath
// Page and frame tables, FIFO queue, allocation count, LRU scan pipeline
// and result register.
// ----------------------------------------------------------------------------
module dpfr_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  dpfr_pkg::ctl_t                    ctl,
  output dpfr_pkg::stat_t                   stat,
  input  dpfr_pkg::request_t                request,
  input  dpfr_pkg::mode_t                   replace_mode,
  input  logic [dpfr_pkg::PAGES_W-1:0]      pages_in_use,
  output dpfr_pkg::result_t                 result,
  output logic                              done
);

  localparam int PHYS_FRAMES = dpfr_pkg::PHYS_FRAMES;
  localparam int VIRT_PAGES  = dpfr_pkg::VIRT_PAGES;
  localparam int PAGE_BYTES  = dpfr_pkg::PAGE_BYTES;
  localparam int FW    = $clog2(PHYS_FRAMES);
  localparam int CW    = $clog2(PHYS_FRAMES + 1);
  localparam int PW    = $clog2(VIRT_PAGES);
  localparam int OFS_W = $clog2(PAGE_BYTES);
  localparam int LW    = 16;   // page number / limit compare width

  typedef struct packed {
    logic                          valid;
    logic                          dirty;
    logic [dpfr_pkg::TIME_W-1:0]   fault_time;
  } page_state_t;

  // memories
  page_state_t      st_mem [VIRT_PAGES];
  logic [FW-1:0]    pf_mem [VIRT_PAGES];
  logic [PW-1:0]    fp_mem [PHYS_FRAMES];
  logic [FW-1:0]    q_mem  [PHYS_FRAMES];

  page_state_t      st_rd, st_wdata;
  logic             st_we;
  logic [PW-1:0]    st_waddr, st_raddr;
  logic [FW-1:0]    pf_rd;
  logic [PW-1:0]    fp_rd;
  logic [FW-1:0]    fp_raddr;
  logic [FW-1:0]    q_rd;

  // item registers
  logic [PW-1:0]                 vpn_q;
  dpfr_pkg::command_t            cmd_q;
  logic [dpfr_pkg::TIME_W-1:0]   time_q;
  logic                          err_q;
  logic [FW-1:0]                 frame_q;
  logic                          evict_q;
  logic [PW-1:0]                 vpage_q;
  logic                          wb_q;

  // control
  logic [CW-1:0]    alloc_cnt;
  logic [FW-1:0]    head, tail;
  logic [PW-1:0]    clr_cnt;
  logic             scan_busy, p1_vld, p2_vld, have;
  logic [FW-1:0]    fcnt, p1_f, p2_f, best_f;
  logic [dpfr_pkg::TIME_W-1:0] best_t;

  logic [LW-1:0]    vpn_in, limit;
  dpfr_pkg::result_t res_next;

  assign vpn_in = LW'(request.virtual_address >> OFS_W);
  assign limit  = (LW'(pages_in_use) < LW'(VIRT_PAGES)) ? LW'(pages_in_use) : LW'(VIRT_PAGES);

  // page state write port
  always_comb begin
    st_we    = 1'b0;
    st_waddr = vpn_q;
    st_wdata = '0;
    if (ctl.clear) begin
      st_we    = 1'b1;
      st_waddr = clr_cnt;
    end else if (ctl.finish && !err_q && st_rd.valid) begin
      st_we          = 1'b1;
      st_wdata.valid = 1'b1;
      if (cmd_q == dpfr_pkg::CMD_MARK_DIRTY) begin
        st_wdata.dirty      = 1'b1;
        st_wdata.fault_time = st_rd.fault_time;
      end else begin
        st_wdata.dirty      = st_rd.dirty;
        st_wdata.fault_time = time_q;
      end
    end else if (ctl.evict) begin
      st_we               = 1'b1;
      st_waddr            = vpage_q;
      st_wdata.fault_time = st_rd.fault_time;
    end else if (ctl.map) begin
      st_we               = 1'b1;
      st_wdata.valid      = 1'b1;
      st_wdata.fault_time = time_q;
    end
  end

  assign st_raddr = ctl.st_from_fp ? fp_rd : vpn_q;
  assign fp_raddr = scan_busy ? fcnt : frame_q;

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rd <= st_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.map) begin
      pf_mem[vpn_q] <= frame_q;
    end
    pf_rd <= pf_mem[vpn_q];
  end

  always_ff @(posedge clk) begin
    if (ctl.map) begin
      fp_mem[frame_q] <= vpn_q;
    end
    fp_rd <= fp_mem[fp_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.map) begin
      q_mem[tail] <= frame_q;
    end
    q_rd <= q_mem[head];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_cnt <= '0;
      head      <= '0;
      tail      <= '0;
      clr_cnt   <= '0;
      scan_busy <= 1'b0;
      p1_vld    <= 1'b0;
      p2_vld    <= 1'b0;
      have      <= 1'b0;
      done      <= 1'b0;
    end else begin
      if (ctl.clear) begin
        clr_cnt <= clr_cnt + PW'(1);
      end
      if (ctl.alloc) begin
        alloc_cnt <= alloc_cnt + CW'(1);
      end
      if (ctl.fifo_take) begin
        head <= (head == FW'(PHYS_FRAMES - 1)) ? '0 : head + FW'(1);
      end
      if (ctl.map) begin
        tail <= (tail == FW'(PHYS_FRAMES - 1)) ? '0 : tail + FW'(1);
      end
      if (ctl.scan_start) begin
        scan_busy <= 1'b1;
      end else if (scan_busy && fcnt == FW'(PHYS_FRAMES - 1)) begin
        scan_busy <= 1'b0;
      end
      p1_vld <= scan_busy;
      p2_vld <= p1_vld;
      if (ctl.scan_start) begin
        have <= 1'b0;
      end else if (p2_vld) begin
        have <= 1'b1;
      end
      done <= ctl.finish | ctl.map;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      vpn_q  <= PW'(vpn_in);
      cmd_q  <= request.command;
      time_q <= request.time_stamp;
      err_q  <= (vpn_in >= limit);
    end
    if (ctl.alloc) begin
      frame_q <= FW'(alloc_cnt);
      evict_q <= 1'b0;
      vpage_q <= '0;
      wb_q    <= 1'b0;
    end
    if (ctl.fifo_take) begin
      frame_q <= q_rd;
    end
    if (ctl.take_best) begin
      frame_q <= best_f;
    end
    if (ctl.capture_victim) begin
      vpage_q <= fp_rd;
    end
    if (ctl.evict) begin
      evict_q <= 1'b1;
      wb_q    <= st_rd.dirty;
    end
    if (ctl.scan_start) begin
      fcnt <= '0;
    end else if (scan_busy) begin
      fcnt <= fcnt + FW'(1);
    end
    p1_f <= fcnt;
    p2_f <= p1_f;
    // strict less-than: earlier (lower) frame keeps ties
    if (p2_vld && (!have || st_rd.fault_time < best_t)) begin
      best_f <= p2_f;
      best_t <= st_rd.fault_time;
    end
    if (ctl.finish || ctl.map) begin
      result <= res_next;
    end
  end

  always_comb begin
    res_next = '0;
    if (ctl.map) begin
      res_next.frame       = dpfr_pkg::FRAME_W'(frame_q);
      res_next.evicted     = evict_q;
      res_next.victim_page = dpfr_pkg::VPAGE_W'(vpage_q);
      res_next.write_back  = wb_q;
    end else if (err_q) begin
      res_next.error = 1'b1;
    end else if (st_rd.valid) begin
      res_next.frame = dpfr_pkg::FRAME_W'(pf_rd);
    end
  end

  assign stat.clear_last = (clr_cnt == PW'(VIRT_PAGES - 1));
  assign stat.err        = err_q;
  assign stat.mark_dirty = (cmd_q == dpfr_pkg::CMD_MARK_DIRTY);
  assign stat.hit        = st_rd.valid;
  assign stat.full       = (alloc_cnt == CW'(PHYS_FRAMES));
  assign stat.lru        = (replace_mode == dpfr_pkg::MODE_LRU);
  assign stat.scan_done  = !scan_busy && !p1_vld && !p2_vld;

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    alloc_cnt <= CW'(PHYS_FRAMES))
    else $error("allocation count past frame count");

  a_victim_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (ctl.fifo_take || ctl.scan_start) |-> stat.full)
    else $error("victim chosen while a free frame exists");

endmodule

// ===== rtl/demand_paging_frame_replacer.sv =====
// ----------------------------------------------------------------------------
// demand_paging_frame_replacer
// Page fault handler for one address space: maps faulting pages to frames,
// picks FIFO or LRU victims once frames run out, tracks dirty pages.
// ----------------------------------------------------------------------------
// Steps, accept to done strobe: resident page, mark-dirty or out-of-range
//   page: lookup and report; free frame: allocate and map; FIFO victim:
//   queue head read, evict, map; LRU victim: a scan reads one frame per cycle
//   through the frame->page table and page state memory, then evict and map.
// Throughput: one item at a time; next item is taken the cycle done shows.
// Reset: synchronous; clears control, then a pass over every page entry
//   clears the page state memory with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module demand_paging_frame_replacer (
  input  logic                                  clk,
  input  logic                                  rst,
  // item in
  input  logic                                  start,
  output logic                                  busy,
  input  dpfr_pkg::request_t                    request,
  // item out
  output logic                                  done,
  output dpfr_pkg::result_t                     result,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dpfr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dpfr_pkg::CFG_DATA_W-1:0]       cfg_data
);

  dpfr_pkg::ctl_t   ctl;
  dpfr_pkg::stat_t  stat;

  // configuration registers; the user must write them only while idle; the block does not enforce it
  dpfr_pkg::mode_t                   replace_mode;
  logic [dpfr_pkg::PAGES_W-1:0]      pages_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      replace_mode <= dpfr_pkg::MODE_FIFO;
      pages_in_use <= dpfr_pkg::PAGES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (dpfr_pkg::cfg_reg_t'(cfg_index))
        dpfr_pkg::REG_REPLACE_MODE: begin
          replace_mode <= dpfr_pkg::mode_t'(cfg_data[0]);
        end
        dpfr_pkg::REG_PAGES_IN_USE: begin
          pages_in_use <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer: lookup, then allocate, or pick a victim and evict, then map
  dpfr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  // tables, queue, LRU scan and result register
  dpfr_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .request      (request),
    .replace_mode (replace_mode),
    .pages_in_use (pages_in_use),
    .result       (result),
    .done         (done)
  );

  // an accepted item keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a result only ever closes out work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without an item in progress");

  // an out-of-range page reports nothing else
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.error) |-> (!result.evicted && !result.write_back &&
                                result.frame == '0 && result.victim_page == '0))
    else $error("error result carries other fields");

  // write-back only for an evicted page
  a_wb_needs_evict: assert property (@(posedge clk) disable iff (rst)
    (done && result.write_back) |-> result.evicted)
    else $error("write_back without eviction");

endmodule

// ===== tb/sv/frame_replacer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_replacer_checker
// Watches the item, result and register channels of the frame replacer.
// Keeps its own page/frame tables and predicts each result, then compares
// every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_replacer_checker
  import dpfr_pkg::*;
#(
  parameter int PHYS_FRAMES = 32,
  parameter int VIRT_PAGES  = 256,
  parameter int PAGE_SHIFT  = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  request_t              request,
  input  logic                  done,
  input  result_t               result,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding
);

  mode_t               replace_mode;
  logic [PAGES_W-1:0]  pages_in_use;

  logic [FRAME_W-1:0]  page_frame [VIRT_PAGES];
  bit                  page_valid [VIRT_PAGES];
  bit                  page_dirty [VIRT_PAGES];
  logic [TIME_W-1:0]   fault_time [VIRT_PAGES];
  bit                  frame_taken [PHYS_FRAMES];
  logic [FRAME_W-1:0]  frame_order [PHYS_FRAMES];
  logic [FRAME_W-1:0]  order_head;
  logic [FRAME_W-1:0]  order_tail;

  result_t             expected_results [$];
  result_t             want;

  function automatic void clear_tables();
    int i;
    replace_mode = MODE_FIFO;
    pages_in_use = PAGES_RESET;
    for (i = 0; i < VIRT_PAGES; i++) begin
      page_frame[i] = '0;
      page_valid[i] = 1'b0;
      page_dirty[i] = 1'b0;
      fault_time[i] = '0;
    end
    for (i = 0; i < PHYS_FRAMES; i++) begin
      frame_taken[i] = 1'b0;
      frame_order[i] = '0;
    end
    order_head = '0;
    order_tail = '0;
  endfunction

  // resident page held in frame fr, -1 if none
  function automatic int owner_of(int fr);
    int p, hit;
    hit = -1;
    for (p = 0; p < VIRT_PAGES; p++)
      if (hit < 0 && page_valid[p] && page_frame[p] == fr)
        hit = p;
    return hit;
  endfunction

  // oldest fault time wins, strict less-than so lowest frame wins ties
  function automatic int oldest_frame();
    int f, p, best;
    bit have;
    logic [TIME_W-1:0] best_time;
    best = 0;
    have = 1'b0;
    best_time = '0;
    for (f = 0; f < PHYS_FRAMES; f++) begin
      if (frame_taken[f]) begin
        p = owner_of(f);
        if (p >= 0 && (!have || fault_time[p] < best_time)) begin
          best = f;
          best_time = fault_time[p];
          have = 1'b1;
        end
      end
    end
    return best;
  endfunction

  function automatic result_t serve_request(request_t req);
    int unsigned vpn, lim;
    int f, slot, victim;
    logic [FRAME_W-1:0] fr;
    result_t res;
    res = '0;
    vpn = 32'(req.virtual_address) >> PAGE_SHIFT;
    lim = (32'(pages_in_use) < VIRT_PAGES) ? 32'(pages_in_use) : VIRT_PAGES;
    if (vpn >= lim) begin
      res.error = 1'b1;
      return res;
    end
    if (req.command == CMD_MARK_DIRTY) begin
      if (page_valid[vpn]) begin
        page_dirty[vpn] = 1'b1;
        res.frame = page_frame[vpn];
      end
      return res;
    end
    fault_time[vpn] = req.time_stamp;
    if (page_valid[vpn]) begin
      res.frame = page_frame[vpn];
      return res;
    end
    slot = -1;
    for (f = 0; f < PHYS_FRAMES; f++)
      if (slot < 0 && !frame_taken[f])
        slot = f;
    if (slot >= 0) begin
      frame_taken[slot] = 1'b1;
      fr = FRAME_W'(slot);
    end else begin
      if (replace_mode == MODE_FIFO) begin
        fr = frame_order[order_head];
        order_head = order_head + 1'b1;
      end else begin
        fr = FRAME_W'(oldest_frame());
      end
      victim = owner_of(int'(fr));
      if (victim >= 0) begin
        res.evicted = 1'b1;
        res.victim_page = VPAGE_W'(victim);
        res.write_back = page_dirty[victim];
        page_valid[victim] = 1'b0;
        page_dirty[victim] = 1'b0;
      end
    end
    page_frame[vpn] = fr;
    page_valid[vpn] = 1'b1;
    page_dirty[vpn] = 1'b0;
    frame_order[order_tail] = fr;
    order_tail = order_tail + 1'b1;
    res.frame = fr;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_tables();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $error("result with none pending: frame %0d", result.frame);
        end else begin
          want = expected_results.pop_front();
          check_field("frame", 32'(want.frame), 32'(result.frame));
          check_field("evicted", 32'(want.evicted), 32'(result.evicted));
          check_field("victim_page", 32'(want.victim_page), 32'(result.victim_page));
          check_field("write_back", 32'(want.write_back), 32'(result.write_back));
          check_field("error", 32'(want.error), 32'(result.error));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_REPLACE_MODE: replace_mode = mode_t'(cfg_data[0]);
          REG_PAGES_IN_USE: pages_in_use = cfg_data[PAGES_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        expected_results.push_back(serve_request(request));
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== tb/sv/demand_paging_frame_replacer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// demand_paging_frame_replacer_tb
// Drives faults and mark-dirty commands through the frame replacer in both
// victim modes and over several page limits; a checker beside the block
// predicts every result and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module demand_paging_frame_replacer_tb;
  import dpfr_pkg::*;

  localparam int OFFSET_W    = 7;          // byte offset bits within a page
  localparam int WORKING_SET = 44;         // a bit over the 32 frames: hits and misses
  localparam int TAIL_CYCLES = 60;         // longer than the slowest item (LRU scan)
  localparam int CYCLE_LIMIT = 500_000;    // several times the slowest legal run

  typedef enum {STAMP_RISING, STAMP_RANDOM, STAMP_MAX} stamp_style_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  request_t              request;
  logic                  done;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    fail_count;
  int                    outstanding;
  int                    cycle_count;
  logic [TIME_W-1:0]     tick;

  demand_paging_frame_replacer uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_replacer_checker frame_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Present one item and hold it until accepted (start high, busy low).
  // Called and returns at a falling edge. An optional idle gap goes first.
  task automatic issue(command_t cmd, logic [VA_W-1:0] addr, logic [TIME_W-1:0] ts,
                       bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start <= 1'b1;
    request <= '{command: cmd, virtual_address: addr, time_stamp: ts};
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // stop sending and wait for every pending result
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // both registers, written back to back once the block is idle
  task automatic configure(mode_t mode, logic [PAGES_W-1:0] pages);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_REPLACE_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_PAGES_IN_USE;
    cfg_data  <= pages;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random items: mostly faults and mark-dirty on a sliding window of pages
  // so that hits, evictions and dirty write-backs all happen; some items
  // land anywhere in the address space.
  task automatic run_phase(int unsigned count, stamp_style_t style, bit gaps);
    int unsigned base, i;
    bit quiet;
    logic [VA_W-1:0] addr;
    logic [TIME_W-1:0] ts;
    command_t cmd;
    base = $urandom_range(0, 255);
    quiet = 1'b0;
    for (i = 0; i < count; i++) begin
      // stretches of back-to-back items between the gappy ones
      if (i % 32 == 0)
        quiet = !gaps || ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 39) == 0)
        base = $urandom_range(0, 255);
      if ($urandom_range(0, 9) == 0)
        addr = VA_W'($urandom);
      else
        addr = {8'((base + $urandom_range(0, WORKING_SET - 1)) % 256),
                OFFSET_W'($urandom)};
      cmd = ($urandom_range(0, 4) == 0) ? CMD_MARK_DIRTY : CMD_FAULT;
      case (style)
        STAMP_RISING: begin
          tick = tick + $urandom_range(0, 2);   // zero steps make ties
          ts = tick;
        end
        STAMP_RANDOM: ts = $urandom;
        default:      ts = '1;
      endcase
      issue(cmd, addr, ts, !quiet);
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    request   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_REPLACE_MODE;
    cfg_data  = '0;
    tick      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed: reset config (FIFO, all 256 pages) ----
    issue(CMD_MARK_DIRTY, 15'h0280, 32'h0, 1'b0);       // non-resident page: no-op
    issue(CMD_FAULT,      15'h0000, 32'h0, 1'b0);       // page 0, lowest free frame
    issue(CMD_FAULT,      15'h7FFF, 32'hFFFF_FFFF, 1'b0); // top page, max time
    issue(CMD_FAULT,      15'h007F, 32'h1, 1'b0);       // page 0 again: resident
    issue(CMD_MARK_DIRTY, 15'h7F80, 32'h0, 1'b0);       // top page goes dirty
    issue(CMD_MARK_DIRTY, 15'h0000, 32'hFFFF_FFFF, 1'b0);
    issue(CMD_FAULT,      15'h2AAA, 32'hAAAA_AAAA, 1'b0);
    issue(CMD_FAULT,      15'h5555, 32'h5555_5555, 1'b0);
    issue(CMD_FAULT,      15'h5555, 32'h0, 1'b0);       // resident, time back to 0

    // smallest limit: only page 0 is in range
    configure(MODE_FIFO, 9'd1);
    issue(CMD_FAULT,      15'h0080, 32'h2, 1'b0);       // page 1: out of range
    issue(CMD_MARK_DIRTY, 15'h7FFF, 32'h3, 1'b0);       // out of range
    issue(CMD_FAULT,      15'h0000, 32'h4, 1'b0);
    issue(CMD_MARK_DIRTY, 15'h007F, 32'h5, 1'b0);

    // limit one below the top page
    configure(MODE_FIFO, 9'd255);
    issue(CMD_FAULT,      15'h7FFF, 32'h6, 1'b0);       // page 255: just out
    issue(CMD_MARK_DIRTY, 15'h7F80, 32'h7, 1'b0);
    issue(CMD_FAULT,      15'h7F7F, 32'h8, 1'b0);       // page 254: just in

    // ---- random phases ----
    configure(MODE_FIFO, 9'd256);
    run_phase(175, STAMP_RISING, 1'b1);
    drain();                                            // let the block run dry once
    run_phase(175, STAMP_RISING, 1'b1);

    configure(MODE_LRU, 9'd256);
    run_phase(350, STAMP_RISING, 1'b1);
    // every time at max: once all resident pages carry it, the lowest frame becomes the victim
    run_phase(150, STAMP_MAX, 1'b1);

    configure(MODE_LRU, 9'd40);
    run_phase(150, STAMP_RANDOM, 1'b1);

    configure(MODE_FIFO, 9'd1);
    run_phase(60, STAMP_RANDOM, 1'b1);

    configure(MODE_FIFO, 9'd200);
    run_phase(250, STAMP_RANDOM, 1'b1);

    // time counter starts near its top and may wrap during this phase
    tick = 32'hFFFF_FF00;
    configure(MODE_LRU, 9'd256);
    run_phase(250, STAMP_RISING, 1'b1);

    // last stretch at full rate, no gaps
    configure(MODE_FIFO, 9'd256);
    run_phase(300, STAMP_RISING, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);               // catch stray results

    if (fail_count == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dpfr_pkg.sv
rtl/dpfr_ctrl.sv
rtl/dpfr_dpath.sv
rtl/demand_paging_frame_replacer.sv
tb/sv/frame_replacer_checker.sv
tb/sv/demand_paging_frame_replacer_tb.sv
